// ----- hdl/lzss_pkg.sv -----
package lzss_pkg;

	localparam int WINDOW_SIZE = 4096;
	localparam int PTR_W = $clog2(WINDOW_SIZE);
	localparam int BYTE_W = 8;
	localparam int LEN_W = 16;
	localparam int REM_W = 5;
	localparam int FLAG_CNT_W = 4;
	localparam int CODE_LEN_W = 4;
	localparam logic [REM_W-1:0] LEN_BIAS = REM_W'(2);
	localparam logic [FLAG_CNT_W-1:0] FLAG_BITS_AFTER_LOAD = FLAG_CNT_W'(7);

	// stream parse phase
	typedef enum logic [7:0] {
		PH_HDR0    = 8'b0000_0001,
		PH_HDR1    = 8'b0000_0010,
		PH_HDR2    = 8'b0000_0100,
		PH_HDR3    = 8'b0000_1000,
		PH_FLAG    = 8'b0001_0000,
		PH_LIT     = 8'b0010_0000,
		PH_CODE_LO = 8'b0100_0000,
		PH_CODE_HI = 8'b1000_0000
	} phase_t;

	// controller sequencing state
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LIT  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_CP   = 4'b1000
	} state_t;

	typedef struct packed {
		logic ld_tgt_lo;
		logic ld_tgt_hi;
		logic ld_lit;
		logic ld_code_lo;
		logic start_copy;
		logic rd;
		logic emit_lit;
		logic emit_copy;
	} lzss_cmd_t;

	typedef struct packed {
		logic finished;
		logic out_free;
		logic copy_last;
	} lzss_stat_t;

endpackage

// ----- hdl/lzss_in_if.sv -----
interface lzss_in_if import lzss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ----- hdl/lzss_out_if.sv -----
interface lzss_out_if import lzss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic              stream_done;

	modport source (output valid, output out_byte, output run_last, output stream_done,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input stream_done,
		output ready);
endinterface

// ----- hdl/lzss_stream_decompressor.sv -----
// header, flag and code bytes: accepted while idle, no output word
// literal: accepted into a holding register, then written to the output register once that is free
// match: each copied byte takes a registered ring read, then an emit
// rate is set by output back-pressure and the 4096-byte history ring, read and written on alternate cycles
// arst_n clears control and counters at once; no clearing pass, unwritten ring entries read zero
module lzss_stream_decompressor import lzss_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	lzss_in_if.sink    in_ch,
	lzss_out_if.source out_ch
);

	// command and status between sequencer and datapath
	lzss_cmd_t  cmd;
	lzss_stat_t stat;

	// the controller tracks the stream phase and the flag bits, and steps each
	// literal or match through emit cycles; it only takes a new input word when idle
	lzss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.stat   (stat),
		.cmd    (cmd)
	);

	// the datapath owns the history ring, the length limit, the copy pointer
	// and the output register that decouples the output from the sequencer
	lzss_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (in_ch.in_byte),
		.cmd     (cmd),
		.stat    (stat),
		.out_ch  (out_ch)
	);

`ifndef SYNTHESIS
	// the word that reaches the declared length always closes its input word
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.stream_done) |-> out_ch.run_last)
		else $error("stream_done word without run_last");

	// once the declared length is reached the stream stays finished
	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat.finished |=> stat.finished)
		else $error("finished status dropped");

	// no input word is taken while a match is being copied
	a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd || cmd.emit_copy) |-> !in_ch.ready)
		else $error("input ready during copy");
`endif

endmodule

// ----- hdl/lzss_ctrl.sv -----
module lzss_ctrl import lzss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lzss_in_if.sink    in_ch,
	input  lzss_stat_t stat,
	output lzss_cmd_t  cmd
);

	state_t                st_q, st_d;
	phase_t                ph_q, ph_d;
	logic [BYTE_W-1:0]     flag_q, flag_d;
	logic [FLAG_CNT_W-1:0] bits_q, bits_d;
	logic                  accept;
	phase_t                adv_ph;
	logic [BYTE_W-1:0]     adv_flag;
	logic [FLAG_CNT_W-1:0] adv_bits;

	assign in_ch.ready = (st_q == ST_IDLE);
	assign accept = in_ch.valid && in_ch.ready;

	// next flag bit, taken after a literal or a finished match
	always_comb begin
		if (bits_q == '0) begin
			adv_ph   = PH_FLAG;
			adv_flag = flag_q;
			adv_bits = bits_q;
		end else begin
			adv_ph   = flag_q[0] ? PH_LIT : PH_CODE_LO;
			adv_flag = flag_q >> 1;
			adv_bits = bits_q - FLAG_CNT_W'(1);
		end
	end

	always_comb begin
		cmd    = '0;
		st_d   = st_q;
		ph_d   = ph_q;
		flag_d = flag_q;
		bits_d = bits_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept && !stat.finished) begin
					unique case (ph_q)
						PH_HDR0: begin
							cmd.ld_tgt_lo = 1'b1;
							ph_d = PH_HDR1;
						end
						PH_HDR1: begin
							cmd.ld_tgt_hi = 1'b1;
							ph_d = PH_HDR2;
						end
						PH_HDR2: ph_d = PH_HDR3;
						PH_HDR3: ph_d = PH_FLAG;
						PH_FLAG: begin
							ph_d   = in_ch.in_byte[0] ? PH_LIT : PH_CODE_LO;
							flag_d = in_ch.in_byte >> 1;
							bits_d = FLAG_BITS_AFTER_LOAD;
						end
						PH_LIT: begin
							cmd.ld_lit = 1'b1;
							st_d = ST_LIT;
						end
						PH_CODE_LO: begin
							cmd.ld_code_lo = 1'b1;
							ph_d = PH_CODE_HI;
						end
						PH_CODE_HI: begin
							cmd.start_copy = 1'b1;
							st_d = ST_RD;
						end
						default: ph_d = PH_HDR0;
					endcase
				end
			end
			ST_LIT: begin
				if (stat.out_free) begin
					cmd.emit_lit = 1'b1;
					ph_d   = adv_ph;
					flag_d = adv_flag;
					bits_d = adv_bits;
					st_d   = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.rd = 1'b1;
				st_d = ST_CP;
			end
			ST_CP: begin
				if (stat.out_free) begin
					cmd.emit_copy = 1'b1;
					if (stat.copy_last) begin
						ph_d   = adv_ph;
						flag_d = adv_flag;
						bits_d = adv_bits;
						st_d   = ST_IDLE;
					end else begin
						st_d = ST_RD;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			ph_q   <= PH_HDR0;
			flag_q <= '0;
			bits_q <= '0;
		end else begin
			st_q   <= st_d;
			ph_q   <= ph_d;
			flag_q <= flag_d;
			bits_q <= bits_d;
		end
	end

endmodule

// ----- hdl/lzss_datapath.sv -----
module lzss_datapath import lzss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] in_byte,
	input  lzss_cmd_t         cmd,
	output lzss_stat_t        stat,
	lzss_out_if.source        out_ch
);

	logic [BYTE_W-1:0] ring_mem [WINDOW_SIZE];
	logic [BYTE_W-1:0] rd_data_q;
	logic              rd_ok_q;
	logic [BYTE_W-1:0] lit_q;
	logic [BYTE_W-1:0] code_lo_q;
	logic [LEN_W-1:0]  tgt_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  cnt_inc;
	logic [PTR_W-1:0]  wpos_q;
	logic              filled_q;
	logic [PTR_W-1:0]  copy_ptr_q;
	logic [REM_W-1:0]  copy_rem_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_done_q;
	logic              emit;
	logic              done_next;
	logic [BYTE_W-1:0] emit_byte;
	logic [PTR_W-1:0]  offset;
	logic [REM_W-1:0]  match_len;

	assign emit      = cmd.emit_lit || cmd.emit_copy;
	assign cnt_inc   = cnt_q + LEN_W'(1);
	assign done_next = (tgt_q != '0) && (cnt_inc >= tgt_q);
	// entries never written since reset read as zero
	assign emit_byte = cmd.emit_lit ? lit_q : (rd_ok_q ? rd_data_q : '0);
	assign offset    = {in_byte[CODE_LEN_W-1:0], code_lo_q};
	assign match_len = REM_W'(in_byte[BYTE_W-1 -: CODE_LEN_W]) + LEN_BIAS;

	assign stat.finished  = (tgt_q != '0) && (cnt_q >= tgt_q);
	assign stat.out_free  = !out_valid_q || out_ch.ready;
	assign stat.copy_last = (copy_rem_q == REM_W'(1)) || done_next;

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.run_last    = out_last_q;
	assign out_ch.stream_done = out_done_q;

	// history ring, read-before-write
	always_ff @(posedge clk) begin
		if (emit) begin
			ring_mem[wpos_q] <= emit_byte;
		end
		if (cmd.rd) begin
			rd_data_q <= ring_mem[copy_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_lit) begin
			lit_q <= in_byte;
		end
		if (cmd.ld_code_lo) begin
			code_lo_q <= in_byte;
		end
		if (cmd.rd) begin
			rd_ok_q <= filled_q || (copy_ptr_q < wpos_q);
		end
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= cmd.emit_lit || stat.copy_last;
			out_done_q <= done_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q       <= '0;
			cnt_q       <= '0;
			wpos_q      <= '0;
			filled_q    <= 1'b0;
			copy_ptr_q  <= '0;
			copy_rem_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ld_tgt_lo) begin
				tgt_q <= LEN_W'(in_byte);
			end
			if (cmd.ld_tgt_hi) begin
				tgt_q[LEN_W-1 -: BYTE_W] <= in_byte;
			end
			if (cmd.start_copy) begin
				copy_ptr_q <= wpos_q - offset;
				copy_rem_q <= match_len;
			end
			if (cmd.rd) begin
				copy_ptr_q <= copy_ptr_q + PTR_W'(1);
			end
			if (cmd.emit_copy) begin
				copy_rem_q <= copy_rem_q - REM_W'(1);
			end
			if (emit) begin
				wpos_q <= wpos_q + PTR_W'(1);
				cnt_q  <= cnt_inc;
				if (wpos_q == '1) begin
					filled_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
